@@ rtl/bitmap_first_fit_allocator_assert.svh @@
// Assertion macro used by the allocator checker.
`ifndef BITMAP_FIRST_FIT_ALLOCATOR_ASSERT_SVH
`define BITMAP_FIRST_FIT_ALLOCATOR_ASSERT_SVH
// Property that holds on every clock edge outside reset.
`define BFA_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`endif

@@ rtl/bfa_pkg.sv @@
// ----------------------------------------------------------------------------
// Bitmap first-fit allocator package
// Shared constants, codes and controller/datapath types.
// ----------------------------------------------------------------------------
package bfa_pkg;
  localparam int unsigned NumUnitsDef   = 65536;
  localparam int unsigned MaxRequestDef = 131072;
  localparam int unsigned WordW         = 64;
  localparam int unsigned SizeW         = 18;
  localparam int unsigned AddrW         = 32;
  localparam int unsigned StatusW       = 2;

  typedef enum logic [1:0] {
    StOk         = 2'd0,
    StBadSize    = 2'd1,
    StNoSpace    = 2'd2,
    StOutOfRange = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    SIdle,
    SScan,
    SScanWait,
    SMark,
    SMarkWait,
    SDone
  } state_e;

  typedef struct packed {
    logic start_scan;
    logic start_mark;
    logic scan_step;
    logic mark_step;
  } ctl_cmd_t;

  typedef struct packed {
    logic scan_found;
    logic scan_end;
    logic mark_end;
  } ctl_sts_t;
endpackage

@@ rtl/bfa_req_if.sv @@
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel that carries one allocate or free item.
// ----------------------------------------------------------------------------
interface bfa_req_if;
  logic                      valid;
  logic                      ready;
  logic                      func;
  logic [bfa_pkg::SizeW-1:0] size;
  logic [bfa_pkg::AddrW-1:0] address;
  modport source (output valid, func, size, address, input ready);
  modport sink (input valid, func, size, address, output ready);
endinterface

@@ rtl/bfa_rsp_if.sv @@
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel that carries one result item.
// ----------------------------------------------------------------------------
interface bfa_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [bfa_pkg::StatusW-1:0] status;
  logic [bfa_pkg::AddrW-1:0]   block_address;
  modport source (output valid, status, block_address, input ready);
  modport sink (input valid, status, block_address, output ready);
endinterface

@@ rtl/bfa_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// Single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module bfa_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end
endmodule

@@ rtl/bfa_datapath.sv @@
// ----------------------------------------------------------------------------
// Allocator datapath
// Bitmap memory with clear pass, word scan, run marking and result forming.
// ----------------------------------------------------------------------------
module bfa_datapath #(
  parameter int unsigned NumUnits   = bfa_pkg::NumUnitsDef,
  parameter int unsigned MaxRequest = bfa_pkg::MaxRequestDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        load_i,
  input  logic                        func_i,
  input  logic [bfa_pkg::SizeW-1:0]   size_i,
  input  logic [bfa_pkg::AddrW-1:0]   address_i,
  input  logic [bfa_pkg::AddrW-1:0]   heap_base_i,
  input  bfa_pkg::ctl_cmd_t           cmd_i,
  output bfa_pkg::ctl_sts_t           sts_o,
  output logic                        clearing_o,
  output logic [bfa_pkg::StatusW-1:0] pre_status_o,
  output logic [bfa_pkg::AddrW-1:0]   block_address_o
);
  localparam int unsigned WordW  = bfa_pkg::WordW;
  localparam int unsigned Words  = (NumUnits + WordW - 1) / WordW;
  localparam int unsigned WAddrW = (Words > 1) ? $clog2(Words) : 1;
  localparam int unsigned UnitW  = $clog2(NumUnits + 1) + 1;
  localparam int unsigned BitW   = $clog2(WordW);

  logic [WAddrW:0]         clr_q, clr_d;
  logic [WAddrW-1:0]       waddr_q, waddr_d;
  logic [UnitW-1:0]        start_q, start_d, run_q, run_d, mark_q, mark_d;
  logic [UnitW-1:0]        size_q, end_q;
  logic                    func_q, found_q, found_d;
  logic                    rd_q, rd_d;
  logic [bfa_pkg::StatusW-1:0] pre_q;
  logic [bfa_pkg::AddrW-1:0]   offs;
  logic [bfa_pkg::AddrW:0]     offs_end;
  logic                    we;
  logic [WAddrW-1:0]       ram_addr;
  logic [WordW-1:0]        wdata, rdata;
  logic [UnitW-1:0]        unit, mark_last;

  assign offs     = address_i - heap_base_i;
  assign offs_end = {1'b0, offs} + {{(bfa_pkg::AddrW+1-bfa_pkg::SizeW){1'b0}}, size_i};
  assign clearing_o = !clr_q[WAddrW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (clearing_o) begin
      clr_q <= (clr_q == (WAddrW+1)'(Words - 1)) ? {1'b1, {WAddrW{1'b0}}} : clr_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      func_q <= func_i;
      size_q <= UnitW'(size_i);
      if (size_i == '0 || 32'(size_i) > 32'(MaxRequest)) begin
        pre_q <= bfa_pkg::StBadSize;
      end else if (func_i && (offs >= 32'(NumUnits) ||
                   offs_end > 33'(NumUnits))) begin
        pre_q <= bfa_pkg::StOutOfRange;
      end else if (!func_i && 32'(size_i) > 32'(NumUnits)) begin
        pre_q <= bfa_pkg::StNoSpace;
      end else begin
        pre_q <= bfa_pkg::StOk;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    waddr_q <= waddr_d;
    start_q <= start_d;
    run_q   <= run_d;
    mark_q  <= mark_d;
    found_q <= found_d;
    rd_q    <= rd_d;
    if (load_i) begin
      end_q <= func_i ? UnitW'(offs) : '0;
    end else if (cmd_i.start_mark && !func_q) begin
      end_q <= start_q;
    end
  end

  // Scan: walk one bit per word each in combinational chain is too long, so
  // the scan handles the registered word bit by bit via a bit counter.
  logic [BitW-1:0] bit_q, bit_d;
  always_ff @(posedge clk_i) bit_q <= bit_d;

  assign unit = UnitW'({waddr_q, bit_q});
  assign mark_last = end_q + size_q - 1'b1;

  // Marking alternates a read and a write of each word, since the
  // single-port RAM cannot write one word and read the next together.
  always_comb begin
    waddr_d = waddr_q;
    bit_d   = bit_q;
    start_d = start_q;
    run_d   = run_q;
    mark_d  = mark_q;
    found_d = found_q;
    rd_d    = rd_q;
    we      = 1'b0;
    wdata   = rdata;
    ram_addr = waddr_q;
    if (clearing_o) begin
      we = 1'b1;
      wdata = '0;
      ram_addr = clr_q[WAddrW-1:0];
    end else if (cmd_i.start_scan) begin
      waddr_d = '0;
      bit_d   = '0;
      start_d = '0;
      run_d   = '0;
      found_d = 1'b0;
      ram_addr = '0;
    end else if (cmd_i.scan_step) begin
      if (rdata[bit_q]) begin
        run_d   = '0;
        start_d = unit + 1'b1;
      end else begin
        run_d = run_q + 1'b1;
        if (run_q + 1'b1 == size_q) found_d = 1'b1;
      end
      bit_d = bit_q + 1'b1;
      if (bit_q == BitW'(WordW - 1)) waddr_d = waddr_q + 1'b1;
      ram_addr = waddr_d;
    end else if (cmd_i.start_mark) begin
      mark_d  = func_q ? end_q : start_q;
      waddr_d = WAddrW'(mark_d >> BitW);
      rd_d    = 1'b0;
      ram_addr = waddr_d;
    end else if (cmd_i.mark_step) begin
      ram_addr = waddr_q;
      if (rd_q) begin
        rd_d = 1'b0;
      end else begin
        we = 1'b1;
        for (int i = 0; i < WordW; i++) begin
          if (UnitW'({waddr_q, BitW'(i)}) >= mark_q &&
              UnitW'({waddr_q, BitW'(i)}) <= mark_last) begin
            wdata[i] = !func_q;
          end
        end
        waddr_d = waddr_q + 1'b1;
        rd_d    = 1'b1;
      end
    end
  end

  assign sts_o.scan_found = found_q;
  assign sts_o.scan_end   = cmd_i.scan_step && !found_d &&
                            (unit == UnitW'(NumUnits - 1));
  assign sts_o.mark_end   = !rd_q &&
                            (UnitW'({waddr_q, BitW'(WordW - 1)}) >= mark_last);

  bfa_ram #(.Width(WordW), .Depth(Words)) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .addr_i (ram_addr),
    .wdata_i(wdata),
    .rdata_o(rdata)
  );

  assign pre_status_o    = pre_q;
  assign block_address_o = heap_base_i + bfa_pkg::AddrW'(start_q);
endmodule

@@ rtl/bfa_ctrl.sv @@
// ----------------------------------------------------------------------------
// Allocator controller
// Sequences validation, scan, marking and result handoff.
// ----------------------------------------------------------------------------
module bfa_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        clearing_i,
  input  logic                        in_valid_i,
  input  logic                        func_i,
  input  logic [bfa_pkg::StatusW-1:0] pre_status_i,
  input  bfa_pkg::ctl_sts_t           sts_i,
  input  logic                        out_ready_i,
  output logic                        in_ready_o,
  output logic                        load_o,
  output bfa_pkg::ctl_cmd_t           cmd_o,
  output logic                        out_valid_o,
  output logic [bfa_pkg::StatusW-1:0] status_o,
  output logic                        addr_sel_o
);
  bfa_pkg::state_e state_q, state_d;
  logic func_q;
  logic [bfa_pkg::StatusW-1:0] st_q, st_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bfa_pkg::SIdle;
      func_q  <= 1'b0;
      st_q    <= bfa_pkg::StOk;
    end else begin
      state_q <= state_d;
      st_q    <= st_d;
      if (load_o) func_q <= func_i;
    end
  end

  always_comb begin
    state_d = state_q;
    st_d    = st_q;
    unique case (state_q)
      bfa_pkg::SIdle: begin
        if (in_valid_i && !clearing_i) state_d = bfa_pkg::SScan;
      end
      bfa_pkg::SScan: begin
        st_d = pre_status_i;
        if (pre_status_i != bfa_pkg::StOk) state_d = bfa_pkg::SDone;
        else if (func_q) state_d = bfa_pkg::SMark;
        else state_d = bfa_pkg::SScanWait;
      end
      bfa_pkg::SScanWait: begin
        if (sts_i.scan_found) state_d = bfa_pkg::SMark;
        else if (sts_i.scan_end) begin
          st_d = bfa_pkg::StNoSpace;
          state_d = bfa_pkg::SDone;
        end
      end
      bfa_pkg::SMark: state_d = bfa_pkg::SMarkWait;
      bfa_pkg::SMarkWait: begin
        if (sts_i.mark_end) state_d = bfa_pkg::SDone;
      end
      bfa_pkg::SDone: begin
        if (out_ready_i) state_d = bfa_pkg::SIdle;
      end
      default: state_d = bfa_pkg::SIdle;
    endcase
  end

  always_comb begin
    in_ready_o  = (state_q == bfa_pkg::SIdle) && !clearing_i;
    load_o      = in_ready_o && in_valid_i;
    cmd_o       = '0;
    cmd_o.start_scan = (state_q == bfa_pkg::SScan);
    cmd_o.scan_step  = (state_q == bfa_pkg::SScanWait) && !sts_i.scan_found;
    cmd_o.start_mark = (state_q == bfa_pkg::SMark);
    cmd_o.mark_step  = (state_q == bfa_pkg::SMarkWait);
    out_valid_o = (state_q == bfa_pkg::SDone);
    status_o    = st_q;
    addr_sel_o  = (st_q == bfa_pkg::StOk) && !func_q;
  end
endmodule

@@ rtl/bitmap_first_fit_allocator.sv @@
// ----------------------------------------------------------------------------
// Bitmap first-fit allocator
// One-bit-per-unit heap bitmap with first-fit allocate and range free.
// ----------------------------------------------------------------------------
// One item is handled at a time. An item rejected for its size or range is
// answered without a scan. An allocate scans the bitmap one unit per cycle
// from unit 0; when no run fits, it is answered with no space once the last
// unit is scanned. A run that is found is written back one 64-bit bitmap word
// at a time, each word read and then written, and a free skips the scan and
// clears its range the same way. The bit-serial scan over the single-port
// bitmap RAM sets the rate. The next item is accepted from the cycle after the
// result is taken. After reset a clearing pass writes zero to every bitmap
// word before the first item is accepted.
module bitmap_first_fit_allocator #(
  parameter int unsigned NumUnits   = bfa_pkg::NumUnitsDef,
  parameter int unsigned MaxRequest = bfa_pkg::MaxRequestDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [bfa_pkg::AddrW-1:0] cfg_wdata_i,
  bfa_req_if.sink                   req,
  bfa_rsp_if.source                 rsp
);
  logic [bfa_pkg::AddrW-1:0]   heap_base_q;
  logic                        clearing, load, addr_sel;
  logic [bfa_pkg::StatusW-1:0] pre_status, status;
  logic [bfa_pkg::AddrW-1:0]   blk_addr;
  bfa_pkg::ctl_cmd_t           cmd;
  bfa_pkg::ctl_sts_t           sts;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) heap_base_q <= '0;
    else if (cfg_we_i) heap_base_q <= cfg_wdata_i;
  end

  bfa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .clearing_i  (clearing),
    .in_valid_i  (req.valid),
    .func_i      (req.func),
    .pre_status_i(pre_status),
    .sts_i       (sts),
    .out_ready_i (rsp.ready),
    .in_ready_o  (req.ready),
    .load_o      (load),
    .cmd_o       (cmd),
    .out_valid_o (rsp.valid),
    .status_o    (status),
    .addr_sel_o  (addr_sel)
  );

  bfa_datapath #(.NumUnits(NumUnits), .MaxRequest(MaxRequest)) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .load_i         (load),
    .func_i         (req.func),
    .size_i         (req.size),
    .address_i      (req.address),
    .heap_base_i    (heap_base_q),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .clearing_o     (clearing),
    .pre_status_o   (pre_status),
    .block_address_o(blk_addr)
  );

  assign rsp.status        = status;
  assign rsp.block_address = addr_sel ? blk_addr : '0;
endmodule

@@ rtl/bfa_checker.sv @@
// ----------------------------------------------------------------------------
// Allocator checker
// Port-level properties of the allocator, bound to the top level.
// ----------------------------------------------------------------------------
`include "bitmap_first_fit_allocator_assert.svh"

module bfa_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [bfa_pkg::StatusW-1:0] status,
  input logic [bfa_pkg::AddrW-1:0]   block_address
);
  `BFA_ASSERT(a_no_accept_busy, clk_i, rst_ni, out_valid |-> !in_ready, "accept while result pending")
  `BFA_ASSERT(a_err_zero_addr, clk_i, rst_ni, (out_valid && status != bfa_pkg::StOk) |-> block_address == '0, "error with address")
  `BFA_ASSERT(a_out_hold, clk_i, rst_ni, (out_valid && !out_ready) |=> out_valid && $stable(status), "result dropped")
endmodule

bind bitmap_first_fit_allocator bfa_checker u_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid     (req.valid),
  .in_ready     (req.ready),
  .out_valid    (rsp.valid),
  .out_ready    (rsp.ready),
  .status       (rsp.status),
  .block_address(rsp.block_address)
);
